/* rtl/npcs_pkg.sv */
// Shared constants, types and the reset palette table of the nearest palette color search.
`default_nettype none

package npcs_pkg;

   // Storage sizes.
   localparam int PALETTE_ENTRIES = 256;
   localparam int SUBSET_ENTRIES  = 16;
   localparam int ROTATE_LENGTH   = 16;

   // Field widths.
   localparam int FUNC_W  = 3;
   localparam int SLOT_W  = 8;
   localparam int CH_W    = 8;
   localparam int COLOR_W = 3 * CH_W;
   localparam int DIST_W  = 10;

   // Derived widths and spans.
   localparam int PAL_IW   = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;
   localparam int SUB_IW   = (SUBSET_ENTRIES > 1) ? $clog2(SUBSET_ENTRIES) : 1;
   localparam int SCAN_LEN = (PALETTE_ENTRIES > SUBSET_ENTRIES) ? PALETTE_ENTRIES
                                                                : SUBSET_ENTRIES;
   localparam int SCAN_W   = $clog2(SCAN_LEN);
   localparam int ROT_SPAN = (ROTATE_LENGTH < SUBSET_ENTRIES) ? ROTATE_LENGTH
                                                              : SUBSET_ENTRIES;

   // A distance must be strictly below this limit to count as a match.
   localparam logic [DIST_W-1:0] DIST_LIMIT = DIST_W'(765);
   localparam int                CUBE_STEP  = 51;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_WRITE_PALETTE  = 3'd0,
      FUNC_WRITE_SUBSET   = 3'd1,
      FUNC_SEARCH_PALETTE = 3'd2,
      FUNC_SEARCH_SUBSET  = 3'd3,
      FUNC_ROTATE_SUBSET  = 3'd4
   } func_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic              pal_write;
      logic              sub_write;
      logic              rotate;
      logic              search_start;
      logic              subset_mode;
      logic              read_en;
      logic [SCAN_W-1:0] read_index;
   } dp_cmd_type;

   typedef logic [PALETTE_ENTRIES-1:0][COLOR_W-1:0] palette_table_type;

   // Power-up palette: black, near black, then the 6x6x5 color cube with blue
   // running fastest. Everything past the cube is black.
   function automatic palette_table_type palette_reset_table();
      palette_table_type tbl;
      int                idx;
      tbl = '0;
      idx = 2;
      if (PALETTE_ENTRIES > 1) begin
         tbl[1] = COLOR_W'(24'h010101);
      end
      for (int r = 0; r < 6; r++) begin
         for (int g = 0; g < 6; g++) begin
            for (int b = 1; b < 6; b++) begin
               if (idx < PALETTE_ENTRIES) begin
                  tbl[idx] = {CH_W'(r * CUBE_STEP), CH_W'(g * CUBE_STEP),
                              CH_W'(b * CUBE_STEP)};
               end
               idx++;
            end
         end
      end
      return tbl;
   endfunction

   localparam palette_table_type PALETTE_RESET = palette_reset_table();

endpackage

`default_nettype wire

/* rtl/npcs_ctrl.sv */
// Controller state machine of the nearest palette color search.
`default_nettype none

module npcs_ctrl (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           start,
   input  wire logic [npcs_pkg::FUNC_W-1:0]    req_func,
   output logic                                busy,
   output logic                                rsp_valid,
   output npcs_pkg::dp_cmd_type                cmd
);

   typedef enum logic [4:0] {
      ST_IDLE    = 5'b00001,
      ST_SCAN    = 5'b00010,
      ST_DRAIN_A = 5'b00100,
      ST_DRAIN_B = 5'b01000,
      ST_REPLY   = 5'b10000
   } state_type;

   state_type                       state_ff, state_in;
   logic [npcs_pkg::SCAN_W-1:0]     cnt_ff, cnt_in;
   logic                            mode_ff, mode_in;
   logic                            accept;
   logic                            last;

   assign busy      = (state_ff != ST_IDLE);
   assign accept    = start && !busy;
   assign rsp_valid = (state_ff == ST_REPLY);

   // Last scan position depends on which table is searched.
   assign last = mode_ff ? (cnt_ff == npcs_pkg::SCAN_W'(npcs_pkg::SUBSET_ENTRIES - 1))
                         : (cnt_ff == npcs_pkg::SCAN_W'(npcs_pkg::PALETTE_ENTRIES - 1));

   always_comb begin
      state_in         = state_ff;
      cnt_in           = cnt_ff;
      mode_in          = mode_ff;
      cmd              = '0;
      cmd.subset_mode  = mode_ff;
      cmd.read_index   = cnt_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (req_func)
                  npcs_pkg::FUNC_WRITE_PALETTE: begin
                     cmd.pal_write = 1'b1;
                  end
                  npcs_pkg::FUNC_WRITE_SUBSET: begin
                     cmd.sub_write = 1'b1;
                  end
                  npcs_pkg::FUNC_SEARCH_PALETTE: begin
                     cmd.search_start = 1'b1;
                     mode_in          = 1'b0;
                     cnt_in           = '0;
                     state_in         = ST_SCAN;
                  end
                  npcs_pkg::FUNC_SEARCH_SUBSET: begin
                     cmd.search_start = 1'b1;
                     mode_in          = 1'b1;
                     cnt_in           = '0;
                     state_in         = ST_SCAN;
                  end
                  npcs_pkg::FUNC_ROTATE_SUBSET: begin
                     cmd.rotate = 1'b1;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_SCAN: begin
            cmd.read_en = 1'b1;
            if (last) begin
               state_in = ST_DRAIN_A;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_DRAIN_A: begin
            state_in = ST_DRAIN_B;
         end
         ST_DRAIN_B: begin
            state_in = ST_REPLY;
         end
         ST_REPLY: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
         mode_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         mode_ff  <= mode_in;
      end
   end

   a_reply_frees: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !busy)
      else $error("block still busy after its reply");

   a_search_busy: assert property (@(posedge clock) disable iff (reset)
      cmd.search_start |=> (busy && !rsp_valid))
      else $error("search did not enter the scan");

   a_reply_after_drain: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(state_ff == ST_DRAIN_B))
      else $error("reply not preceded by pipeline drain");

endmodule

`default_nettype wire

/* rtl/npcs_dp.sv */
// Datapath of the nearest palette color search: palette RAM, subset table and distance pipeline.
`default_nettype none

module npcs_dp (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire npcs_pkg::dp_cmd_type            cmd,
   input  wire logic [npcs_pkg::SLOT_W-1:0]     req_slot,
   input  wire logic [npcs_pkg::CH_W-1:0]       req_red,
   input  wire logic [npcs_pkg::CH_W-1:0]       req_green,
   input  wire logic [npcs_pkg::CH_W-1:0]       req_blue,
   input  wire logic [npcs_pkg::SLOT_W-1:0]     req_pointer_value,
   output logic [npcs_pkg::SLOT_W-1:0]          best_index
);

   localparam int CMP_W = npcs_pkg::SLOT_W + 1;

   // Palette RAM with one valid flag per entry; an unwritten entry reads as its power-up color.
   logic [npcs_pkg::COLOR_W-1:0]      pal_mem [npcs_pkg::PALETTE_ENTRIES];
   logic [npcs_pkg::PALETTE_ENTRIES-1:0] pal_valid_ff;
   logic [npcs_pkg::SLOT_W-1:0]       sub_ff [npcs_pkg::SUBSET_ENTRIES];

   logic [npcs_pkg::CH_W-1:0]         key_r_ff, key_g_ff, key_b_ff;

   logic                              pal_slot_ok, sub_slot_ok;
   logic [npcs_pkg::SLOT_W-1:0]       sub_ptr;
   logic [npcs_pkg::PAL_IW-1:0]       rd_addr;
   logic                              rd_oob;

   // Stage 1: RAM read.
   logic                              vld_s1_ff;
   logic [npcs_pkg::COLOR_W-1:0]      rdata_s1_ff;
   logic                              written_s1_ff;
   logic                              oob_s1_ff;
   logic [npcs_pkg::PAL_IW-1:0]       addr_s1_ff;
   logic [npcs_pkg::SCAN_W-1:0]       pos_s1_ff;

   // Stage 2: distance.
   logic [npcs_pkg::COLOR_W-1:0]      color_s1;
   logic [npcs_pkg::CH_W-1:0]         dr, dg, db;
   logic [npcs_pkg::DIST_W-1:0]       dist_in;
   logic                              vld_s2_ff;
   logic [npcs_pkg::DIST_W-1:0]       dist_s2_ff;
   logic [npcs_pkg::SCAN_W-1:0]       pos_s2_ff;

   // Stage 3: running minimum.
   logic [npcs_pkg::DIST_W-1:0]       best_dist_ff;
   logic [npcs_pkg::SCAN_W-1:0]       best_pos_ff;

   assign pal_slot_ok = (CMP_W'(req_slot) < CMP_W'(npcs_pkg::PALETTE_ENTRIES));
   assign sub_slot_ok = (CMP_W'(req_slot) < CMP_W'(npcs_pkg::SUBSET_ENTRIES));

   assign sub_ptr = sub_ff[cmd.read_index[npcs_pkg::SUB_IW-1:0]];
   assign rd_addr = cmd.subset_mode ? sub_ptr[npcs_pkg::PAL_IW-1:0]
                                    : cmd.read_index[npcs_pkg::PAL_IW-1:0];
   assign rd_oob  = cmd.subset_mode
                    && (CMP_W'(sub_ptr) >= CMP_W'(npcs_pkg::PALETTE_ENTRIES));

   always_ff @(posedge clock) begin
      if (cmd.pal_write && pal_slot_ok) begin
         pal_mem[req_slot[npcs_pkg::PAL_IW-1:0]] <= {req_red, req_green, req_blue};
      end
      if (cmd.read_en) begin
         rdata_s1_ff <= pal_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pal_valid_ff <= '0;
      end else if (cmd.pal_write && pal_slot_ok) begin
         pal_valid_ff[req_slot[npcs_pkg::PAL_IW-1:0]] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.sub_write && sub_slot_ok) begin
         sub_ff[req_slot[npcs_pkg::SUB_IW-1:0]] <= req_pointer_value;
      end else if (cmd.rotate) begin
         for (int i = 0; i < npcs_pkg::ROT_SPAN - 1; i++) begin
            sub_ff[i] <= sub_ff[i + 1];
         end
         sub_ff[npcs_pkg::ROT_SPAN - 1] <= sub_ff[0];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.search_start) begin
         key_r_ff <= req_red;
         key_g_ff <= req_green;
         key_b_ff <= req_blue;
      end
      written_s1_ff <= pal_valid_ff[rd_addr];
      oob_s1_ff     <= rd_oob;
      addr_s1_ff    <= rd_addr;
      pos_s1_ff     <= cmd.read_index;
   end

   assign color_s1 = oob_s1_ff     ? '0 :
                     written_s1_ff ? rdata_s1_ff :
                                     npcs_pkg::PALETTE_RESET[addr_s1_ff];

   always_comb begin
      dr = (color_s1[23:16] > key_r_ff) ? (color_s1[23:16] - key_r_ff)
                                        : (key_r_ff - color_s1[23:16]);
      dg = (color_s1[15:8] > key_g_ff) ? (color_s1[15:8] - key_g_ff)
                                       : (key_g_ff - color_s1[15:8]);
      db = (color_s1[7:0] > key_b_ff) ? (color_s1[7:0] - key_b_ff)
                                      : (key_b_ff - color_s1[7:0]);
      dist_in = npcs_pkg::DIST_W'(dr) + npcs_pkg::DIST_W'(dg) + npcs_pkg::DIST_W'(db);
   end

   always_ff @(posedge clock) begin
      dist_s2_ff <= dist_in;
      pos_s2_ff  <= pos_s1_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_s1_ff <= 1'b0;
         vld_s2_ff <= 1'b0;
      end else begin
         vld_s1_ff <= cmd.read_en;
         vld_s2_ff <= vld_s1_ff;
      end
   end

   // Strict compare keeps the first position among equal distances.
   always_ff @(posedge clock) begin
      if (cmd.search_start) begin
         best_dist_ff <= npcs_pkg::DIST_LIMIT;
         best_pos_ff  <= '0;
      end else if (vld_s2_ff && (dist_s2_ff < best_dist_ff)) begin
         best_dist_ff <= dist_s2_ff;
         best_pos_ff  <= pos_s2_ff;
      end
   end

   assign best_index = npcs_pkg::SLOT_W'(best_pos_ff);

   a_min_monotonic: assert property (@(posedge clock) disable iff (reset)
      (vld_s2_ff && !cmd.search_start) |=> (best_dist_ff <= $past(best_dist_ff)))
      else $error("running minimum grew during a scan");

   a_scan_in_range: assert property (@(posedge clock) disable iff (reset)
      (cmd.read_en && cmd.subset_mode)
      |-> (cmd.read_index < npcs_pkg::SCAN_W'(npcs_pkg::SUBSET_ENTRIES - 1)
           || cmd.read_index == npcs_pkg::SCAN_W'(npcs_pkg::SUBSET_ENTRIES - 1)))
      else $error("subset scan ran past the table");

   a_search_clears_best: assert property (@(posedge clock) disable iff (reset)
      cmd.search_start |=> (best_dist_ff == npcs_pkg::DIST_LIMIT && best_pos_ff == '0))
      else $error("running minimum not cleared at search start");

endmodule

`default_nettype wire

/* rtl/nearest_palette_color_search.sv */
// Top level of the nearest palette color search.
`default_nettype none

// The block holds a palette of 256 colors and a 16-entry subset table of
// palette indices, and handles one transaction at a time: a transaction is
// taken at a rising edge where start is high and busy is low. Palette writes,
// subset writes and subset rotations complete in the cycle they are taken and
// give no result, so the next transaction can follow immediately. A search
// walks the table one entry per clock through the single read port of the
// palette RAM, plus a three-stage read and compare pipeline. A search holds
// busy until its answer appears on rsp_nearest_index with rsp_valid high for
// exactly one cycle, the last busy cycle. The next transaction can be taken
// in the cycle after that strobe. The receiver has no way to stall that
// strobe, so it must capture the result in that cycle. A search returns the
// first position whose sum of absolute channel differences is smallest and
// below 765, or 0 when none is. After reset the palette holds the 6x6x5
// color cube without any clearing pass; the subset table must be written
// before it is searched.
module nearest_palette_color_search (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   output logic                               busy,
   input  wire logic [npcs_pkg::FUNC_W-1:0]   req_func,
   input  wire logic [npcs_pkg::SLOT_W-1:0]   req_slot,
   input  wire logic [npcs_pkg::CH_W-1:0]     req_red,
   input  wire logic [npcs_pkg::CH_W-1:0]     req_green,
   input  wire logic [npcs_pkg::CH_W-1:0]     req_blue,
   input  wire logic [npcs_pkg::SLOT_W-1:0]   req_pointer_value,
   output logic                               rsp_valid,
   output logic [npcs_pkg::SLOT_W-1:0]        rsp_nearest_index
);

   // Commands decoded by the controller drive every datapath action.
   npcs_pkg::dp_cmd_type cmd;

   npcs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .req_func  (req_func),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .cmd       (cmd)
   );

   // The datapath's best position is final in the reply cycle and feeds the
   // result port directly.
   npcs_dp u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .req_slot          (req_slot),
      .req_red           (req_red),
      .req_green         (req_green),
      .req_blue          (req_blue),
      .req_pointer_value (req_pointer_value),
      .best_index        (rsp_nearest_index)
   );

endmodule

`default_nettype wire
